FILE: design/triangle_unit_normal_top_macros.svh
`ifndef TRIANGLE_UNIT_NORMAL_TOP_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TUN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tun_pkg.sv
package tun_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int NORMAL_WIDTH_DEF = 16;

  localparam int Q_W   = 31;
  localparam int ALIGN = 30;
  localparam int SQ_W  = 2 * Q_W;
  localparam int S_W   = 64;
  localparam int R_W   = 32;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tun_tag_t;

  localparam int AUX_W = 3 * Q_W + $bits(tun_tag_t);

endpackage

FILE: design/tun_cross.sv
module tun_cross import tun_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [CW-1:0]  ca_i [3],
  input  logic signed [CW-1:0]  cb_i [3],
  input  logic signed [CW-1:0]  cc_i [3],
  output logic                  valid_o,
  output logic [2*CW+1:0]       m_o [3],
  output logic [2:0]            neg_o
);

  localparam int EW  = CW + 1;
  localparam int MW  = CW + 1;
  localparam int HW  = (MW + 1) / 2;
  localparam int PPW = 2 * HW;
  localparam int FW  = 4 * HW;
  localparam int CPW = 2 * CW + 3;
  localparam int MGW = 2 * CW + 2;
  localparam int IA [3] = '{1, 2, 0};
  localparam int IB [3] = '{2, 0, 1};

  logic [3:0]           vld_q;
  logic [MW-1:0]        mag_d [2][3];
  logic [MW-1:0]        mag_q [2][3];
  logic                 sg_d  [2][3];
  logic                 sg_q  [2][3];
  logic [PPW-1:0]       pp_d  [6][4];
  logic [PPW-1:0]       pp_q  [6][4];
  logic                 psg_d [6];
  logic                 psg_q [6];
  logic signed [CPW-1:0] prod_d [6];
  logic signed [CPW-1:0] prod_q [6];
  logic [MGW-1:0]       m_d   [3];
  logic [MGW-1:0]       m_q   [3];
  logic [2:0]           neg_d;
  logic [2:0]           neg_q;

  always_comb begin
    logic signed [EW-1:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = EW'(cb_i[i]) - EW'(ca_i[i]);
      sg_d[0][i]  = diff[EW-1];
      mag_d[0][i] = diff[EW-1] ? MW'(-diff) : MW'(diff);
      diff = EW'(cc_i[i]) - EW'(ca_i[i]);
      sg_d[1][i]  = diff[EW-1];
      mag_d[1][i] = diff[EW-1] ? MW'(-diff) : MW'(diff);
    end
  end

  always_comb begin
    logic [MW-1:0] x;
    logic [MW-1:0] y;
    logic [HW-1:0] xl, xh, yl, yh;
    for (int j = 0; j < 6; j++) begin
      if (j % 2 == 0) begin
        x = mag_q[0][IA[j/2]];
        y = mag_q[1][IB[j/2]];
        psg_d[j] = sg_q[0][IA[j/2]] ^ sg_q[1][IB[j/2]];
      end else begin
        x = mag_q[0][IB[j/2]];
        y = mag_q[1][IA[j/2]];
        psg_d[j] = sg_q[0][IB[j/2]] ^ sg_q[1][IA[j/2]];
      end
      xl = x[HW-1:0];
      xh = HW'(x >> HW);
      yl = y[HW-1:0];
      yh = HW'(y >> HW);
      pp_d[j][0] = PPW'(xl) * PPW'(yl);
      pp_d[j][1] = PPW'(xl) * PPW'(yh);
      pp_d[j][2] = PPW'(xh) * PPW'(yl);
      pp_d[j][3] = PPW'(xh) * PPW'(yh);
    end
  end

  always_comb begin
    logic [FW-1:0]  sum;
    logic [CPW-1:0] pm;
    for (int j = 0; j < 6; j++) begin
      sum = FW'(pp_q[j][0]) + (FW'(pp_q[j][1]) << HW) + (FW'(pp_q[j][2]) << HW)
          + (FW'(pp_q[j][3]) << PPW);
      pm = {1'b0, sum[2*MW-1:0]};
      prod_d[j] = psg_q[j] ? -$signed(pm) : $signed(pm);
    end
  end

  always_comb begin
    logic signed [CPW-1:0] n;
    for (int i = 0; i < 3; i++) begin
      n        = prod_q[2*i] - prod_q[2*i+1];
      neg_d[i] = n[CPW-1];
      m_d[i]   = n[CPW-1] ? MGW'(-n) : MGW'(n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    sg_q   <= sg_d;
    pp_q   <= pp_d;
    psg_q  <= psg_d;
    prod_q <= prod_d;
    m_q    <= m_d;
    neg_q  <= neg_d;
  end

  assign valid_o = vld_q[3];
  assign m_o     = m_q;
  assign neg_o   = neg_q;

endmodule

FILE: design/tun_prep.sv
module tun_prep import tun_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [2*CW+1:0]   m_i [3],
  input  logic [2:0]        neg_i,
  output logic              valid_o,
  output logic [S_W-1:0]    s_o,
  output logic [AUX_W-1:0]  aux_o
);

  localparam int MGW = 2 * CW + 2;
  localparam int PW  = $clog2(MGW);
  localparam int XW  = MGW + ALIGN;

  logic [3:0]      vld_q;
  logic [MGW-1:0]  m5_q [3];
  logic [PW-1:0]   p_d, p_q;
  tun_tag_t        tag_d, tag5_q, tag6_q, tag7_q, tag8_q;
  logic [Q_W-1:0]  q_d [3];
  logic [Q_W-1:0]  q6_q [3];
  logic [Q_W-1:0]  q7_q [3];
  logic [Q_W-1:0]  q8_q [3];
  logic [SQ_W-1:0] sq_d [3];
  logic [SQ_W-1:0] sq_q [3];
  logic [S_W-1:0]  s_d, s_q;

  always_comb begin
    logic [MGW-1:0] all;
    all = m_i[0] | m_i[1] | m_i[2];
    p_d = '0;
    for (int b = 0; b < MGW; b++) begin
      if (all[b]) begin
        p_d = PW'(b);
      end
    end
    tag_d.neg   = neg_i;
    tag_d.degen = (all == '0);
  end

  always_comb begin
    logic [XW-1:0] x;
    for (int i = 0; i < 3; i++) begin
      x      = (XW'(m5_q[i]) << ALIGN) >> p_q;
      q_d[i] = x[Q_W-1:0];
      sq_d[i] = SQ_W'(q6_q[i]) * SQ_W'(q6_q[i]);
    end
    s_d = S_W'(sq_q[0]) + S_W'(sq_q[1]) + S_W'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    m5_q   <= m_i;
    p_q    <= p_d;
    tag5_q <= tag_d;
    q6_q   <= q_d;
    tag6_q <= tag5_q;
    sq_q   <= sq_d;
    q7_q   <= q6_q;
    tag7_q <= tag6_q;
    s_q    <= s_d;
    q8_q   <= q7_q;
    tag8_q <= tag7_q;
  end

  assign valid_o = vld_q[3];
  assign s_o     = s_q;
  assign aux_o   = {q8_q[0], q8_q[1], q8_q[2], tag8_q};

endmodule

FILE: design/tun_sqrt.sv
module tun_sqrt import tun_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [S_W-1:0]   s_i,
  input  logic [AUX_W-1:0] aux_i,
  output logic             valid_o,
  output logic [R_W-1:0]   root_o,
  output logic [AUX_W-1:0] aux_o
);

  logic             vld_s  [R_W+1];
  logic [R_W:0]     rem_s  [R_W+1];
  logic [R_W-1:0]   root_s [R_W+1];
  logic [S_W-1:0]   rad_s  [R_W+1];
  logic [AUX_W-1:0] aux_s  [R_W+1];

  assign vld_s[0]  = valid_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = s_i;
  assign aux_s[0]  = aux_i;

  for (genvar g = 0; g < R_W; g++) begin : g_stage
    logic             vld_q;
    logic [R_W:0]     rem_d, rem_q;
    logic [R_W-1:0]   root_d, root_q;
    logic [S_W-1:0]   rad_q;
    logic [AUX_W-1:0] aux_q;

    always_comb begin
      logic [R_W+1:0] sh;
      logic [R_W+1:0] trial;
      sh    = {rem_s[g][R_W-1:0], rad_s[g][S_W-1 -: 2]};
      trial = {root_s[g], 2'b01};
      if (sh >= trial) begin
        rem_d  = (R_W+1)'(sh - trial);
        root_d = {root_s[g][R_W-2:0], 1'b1};
      end else begin
        rem_d  = sh[R_W:0];
        root_d = {root_s[g][R_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_s[g] << 2;
      aux_q  <= aux_s[g];
    end

    assign vld_s[g+1]  = vld_q;
    assign rem_s[g+1]  = rem_q;
    assign root_s[g+1] = root_q;
    assign rad_s[g+1]  = rad_q;
    assign aux_s[g+1]  = aux_q;
  end

  assign valid_o = vld_s[R_W];
  assign root_o  = root_s[R_W];
  assign aux_o   = aux_s[R_W];

endmodule

FILE: design/tun_div.sv
module tun_div import tun_pkg::*; #(
  parameter int NW = NORMAL_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [R_W-1:0]   r_i,
  input  logic [AUX_W-1:0] aux_i,
  output logic             valid_o,
  output logic [NW-2:0]    quot_o [3],
  output tun_tag_t         tag_o
);

  localparam int F    = NW - 2;
  localparam int D    = F + 1;
  localparam int NUMW = F + Q_W + 1;

  logic           vld_s  [D+1];
  logic [R_W-1:0] r_s    [D+1];
  tun_tag_t       tag_s  [D+1];
  logic [R_W-1:0] rem_s  [D+1][3];
  logic [D-1:0]   low_s  [D+1][3];
  logic [D-1:0]   quot_s [D+1][3];

  always_comb begin
    logic [NUMW-1:0] num;
    logic [Q_W-1:0]  q;
    for (int i = 0; i < 3; i++) begin
      q   = aux_i[$bits(tun_tag_t) + (2-i)*Q_W +: Q_W];
      num = (NUMW'(q) << F) + NUMW'(r_i >> 1);
      rem_s[0][i]  = R_W'(num[NUMW-1:D]);
      low_s[0][i]  = num[D-1:0];
      quot_s[0][i] = '0;
    end
  end

  assign vld_s[0] = valid_i;
  assign r_s[0]   = r_i;
  assign tag_s[0] = aux_i[$bits(tun_tag_t)-1:0];

  for (genvar g = 0; g < D; g++) begin : g_stage
    logic           vld_q;
    logic [R_W-1:0] r_q;
    tun_tag_t       tag_q;
    logic [R_W-1:0] rem_d  [3];
    logic [R_W-1:0] rem_q  [3];
    logic [D-1:0]   low_q  [3];
    logic [D-1:0]   quot_d [3];
    logic [D-1:0]   quot_q [3];

    always_comb begin
      logic [R_W:0] sh;
      for (int i = 0; i < 3; i++) begin
        sh = {rem_s[g][i], low_s[g][i][D-1]};
        if (sh >= {1'b0, r_s[g]}) begin
          rem_d[i]  = R_W'(sh - {1'b0, r_s[g]});
          quot_d[i] = {quot_s[g][i][D-2:0], 1'b1};
        end else begin
          rem_d[i]  = sh[R_W-1:0];
          quot_d[i] = {quot_s[g][i][D-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[g];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q    <= r_s[g];
      tag_q  <= tag_s[g];
      rem_q  <= rem_d;
      quot_q <= quot_d;
      for (int i = 0; i < 3; i++) begin
        low_q[i] <= low_s[g][i] << 1;
      end
    end

    assign vld_s[g+1]  = vld_q;
    assign r_s[g+1]    = r_q;
    assign tag_s[g+1]  = tag_q;
    assign rem_s[g+1]  = rem_q;
    assign low_s[g+1]  = low_q;
    assign quot_s[g+1] = quot_q;
  end

  assign valid_o = vld_s[D];
  assign tag_o   = tag_s[D];
  assign quot_o  = quot_s[D];

endmodule

FILE: design/triangle_unit_normal_top.sv
// Unit normal of a triangle. One word of three corners (Q15.16) is taken in every
// cycle, since busy_o stays low; the unit normal (Q1.14 at the default width) and the
// degenerate flag appear on valid_o once the word has passed through the pipeline:
// four stages for edges and cross product, four for alignment and the sum
// of squares, 32 for the bit-serial square root and NORMAL_WIDTH - 1 for the three
// parallel dividers, plus the output register. The receiver cannot stall, so each
// result is shown for one cycle only and must be captured then.
module triangle_unit_normal_top import tun_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [COORD_WIDTH-1:0]  a_x_i,
  input  logic signed [COORD_WIDTH-1:0]  a_y_i,
  input  logic signed [COORD_WIDTH-1:0]  a_z_i,
  input  logic signed [COORD_WIDTH-1:0]  b_x_i,
  input  logic signed [COORD_WIDTH-1:0]  b_y_i,
  input  logic signed [COORD_WIDTH-1:0]  b_z_i,
  input  logic signed [COORD_WIDTH-1:0]  c_x_i,
  input  logic signed [COORD_WIDTH-1:0]  c_y_i,
  input  logic signed [COORD_WIDTH-1:0]  c_z_i,
  output logic                           valid_o,
  output logic signed [NORMAL_WIDTH-1:0] norm_x_o,
  output logic signed [NORMAL_WIDTH-1:0] norm_y_o,
  output logic signed [NORMAL_WIDTH-1:0] norm_z_o,
  output logic                           degenerate_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int NW  = NORMAL_WIDTH;
  localparam int MGW = 2 * CW + 2;

  logic signed [CW-1:0] ca [3];
  logic signed [CW-1:0] cb [3];
  logic signed [CW-1:0] cc [3];

  logic             x_vld;
  logic [MGW-1:0]   x_m [3];
  logic [2:0]       x_neg;
  logic             p_vld;
  logic [S_W-1:0]   p_s;
  logic [AUX_W-1:0] p_aux;
  logic             r_vld;
  logic [R_W-1:0]   r_root;
  logic [AUX_W-1:0] r_aux;
  logic             d_vld;
  logic [NW-2:0]    d_quot [3];
  tun_tag_t         d_tag;

  logic                 valid_q;
  logic signed [NW-1:0] norm_d [3];
  logic signed [NW-1:0] norm_q [3];
  logic                 degen_q;

  assign busy_o = 1'b0;

  assign ca = '{a_x_i, a_y_i, a_z_i};
  assign cb = '{b_x_i, b_y_i, b_z_i};
  assign cc = '{c_x_i, c_y_i, c_z_i};

  tun_cross #(.CW(CW)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .ca_i    (ca),
    .cb_i    (cb),
    .cc_i    (cc),
    .valid_o (x_vld),
    .m_o     (x_m),
    .neg_o   (x_neg)
  );

  tun_prep #(.CW(CW)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x_vld),
    .m_i     (x_m),
    .neg_i   (x_neg),
    .valid_o (p_vld),
    .s_o     (p_s),
    .aux_o   (p_aux)
  );

  tun_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_vld),
    .s_i     (p_s),
    .aux_i   (p_aux),
    .valid_o (r_vld),
    .root_o  (r_root),
    .aux_o   (r_aux)
  );

  tun_div #(.NW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_vld),
    .r_i     (r_root),
    .aux_i   (r_aux),
    .valid_o (d_vld),
    .quot_o  (d_quot),
    .tag_o   (d_tag)
  );

  always_comb begin
    logic signed [NW-1:0] v;
    for (int i = 0; i < 3; i++) begin
      v = $signed(NW'(d_quot[i]));
      if (d_tag.degen) begin
        norm_d[i] = '0;
      end else if (d_tag.neg[i]) begin
        norm_d[i] = -v;
      end else begin
        norm_d[i] = v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q  <= norm_d;
    degen_q <= d_tag.degen;
  end

  assign valid_o      = valid_q;
  assign norm_x_o     = norm_q[0];
  assign norm_y_o     = norm_q[1];
  assign norm_z_o     = norm_q[2];
  assign degenerate_o = degen_q;

endmodule

FILE: design/tun_checker.sv
`include "triangle_unit_normal_top_macros.svh"

module tun_checker import tun_pkg::*; #(
  parameter int NW = NORMAL_WIDTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 valid_o,
  input logic signed [NW-1:0] norm_x_o,
  input logic signed [NW-1:0] norm_y_o,
  input logic signed [NW-1:0] norm_z_o,
  input logic                 degenerate_o
);

  localparam int LAT = NW + 40;
  localparam logic signed [NW-1:0] LIM  = NW'(1) << (NW - 2);
  localparam logic signed [NW-1:0] NLIM = -LIM;

  `TUN_ASSERT_IMPL(a_busy_low, 1'b1, !busy_o, "busy raised on a pipeline that never stalls")
  `TUN_ASSERT_IMPL(a_degen_zero, valid_o && degenerate_o,
                   norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0,
                   "degenerate word with a nonzero normal")
  `TUN_ASSERT_IMPL(a_range, valid_o,
                   norm_x_o <= LIM && norm_x_o >= NLIM && norm_y_o <= LIM &&
                   norm_y_o >= NLIM && norm_z_o <= LIM && norm_z_o >= NLIM,
                   "normal component out of unit range")
  `TUN_ASSERT_IMPL(a_latency, valid_o, $past(start_i && !busy_o, LAT),
                   "result word without an accepted word at the fixed latency")

endmodule

bind triangle_unit_normal_top tun_checker #(.NW(NORMAL_WIDTH)) u_tun_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .valid_o      (valid_o),
  .norm_x_o     (norm_x_o),
  .norm_y_o     (norm_y_o),
  .norm_z_o     (norm_z_o),
  .degenerate_o (degenerate_o)
);
